FILE: rtl/core/lfpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared widths, constants, register map and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    // Field and internal widths
    localparam int SAMPLE_W  = 12;
    localparam int NORM_W    = 10;               // normalised value, 0..1000
    localparam int ERR_W     = 11;               // error, -1000..1000
    localparam int DIFF_W    = ERR_W + 1;        // error difference for D
    localparam int INTEG_W   = 32;
    localparam int GAIN_W    = 32;
    localparam int FRAC_BITS = 24;
    localparam int PROD_W    = 64;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int ACC_W     = TERM_W + 2;
    localparam int DRIVE_W   = ACC_W + 1;
    localparam int NUM_W     = 22;               // (clamped - low) * 1000
    localparam int CNT_W     = 4;
    localparam int DUTY_W    = 8;
    localparam int SPEED_W   = 8;
    localparam int SLOW_W    = 6;                // ceil(|err| / 20) <= 50
    localparam int RECIP_W   = 12;
    localparam int RECIP_SH  = 16;
    localparam int SLOWP_W   = NORM_W + RECIP_W;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    // Constants of the control law
    localparam logic [NORM_W-1:0]  SCALE_MAX  = 10'd1000;
    localparam logic [NORM_W-1:0]  LOST_LEVEL = 10'd100;
    localparam logic [NORM_W-1:0]  ROUND_UP   = 10'd19;    // ceil for /20
    localparam logic [RECIP_W-1:0] RECIP_20   = 12'd3277;  // 2^16 / 20, rounded up
    localparam logic [CNT_W-1:0]   DIV_LAST_BIT = CNT_W'(NORM_W - 1);
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 32'sh8000_0000;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 43'sd255;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -43'sd255;
    localparam logic [DUTY_W-1:0]  DUTY_FULL  = 8'd255;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] LEFT_LOW_RST    = 12'd98;
    localparam logic [SAMPLE_W-1:0] LEFT_HIGH_RST   = 12'd963;
    localparam logic [SAMPLE_W-1:0] RIGHT_LOW_RST   = 12'd77;
    localparam logic [SAMPLE_W-1:0] RIGHT_HIGH_RST  = 12'd2395;
    localparam logic [SPEED_W-1:0]  CRUISE_DUTY_RST = 8'd60;
    localparam logic [GAIN_W-1:0]   GAIN_P_RST      = 32'd3355443;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST      = 32'd3355;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST      = 32'd3355443;

    // Register map, word index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_LEFT_LOW    = 3'd0,
        REG_LEFT_HIGH   = 3'd1,
        REG_RIGHT_LOW   = 3'd2,
        REG_RIGHT_HIGH  = 3'd3,
        REG_CRUISE_DUTY = 3'd4,
        REG_GAIN_P      = 3'd5,
        REG_GAIN_I      = 3'd6,
        REG_GAIN_D      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_low;
        logic [SAMPLE_W-1:0] left_high;
        logic [SAMPLE_W-1:0] right_low;
        logic [SAMPLE_W-1:0] right_high;
        logic [SPEED_W-1:0]  cruise_duty;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
    } cfg_t;

    // Operand select of the shared multiplier
    typedef enum logic [1:0] {
        OP_P = 2'd0,
        OP_I = 2'd1,
        OP_D = 2'd2
    } mul_op_t;

    typedef struct packed {
        logic    load_in;
        logic    prep;
        logic    prep_right;
        logic    store_left;
        logic    div_step;
        logic    calc_err;
        logic    mul_en;
        mul_op_t mul_op;
        logic    acc_en;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/lfpd_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_regs
// APB register file: calibration bounds, base speed and the three gains.
// ----------------------------------------------------------------------------
module lfpd_regs
    import lfpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LEFT_LOW:    cfg_next.left_low    = pwdata[SAMPLE_W-1:0];
                REG_LEFT_HIGH:   cfg_next.left_high   = pwdata[SAMPLE_W-1:0];
                REG_RIGHT_LOW:   cfg_next.right_low   = pwdata[SAMPLE_W-1:0];
                REG_RIGHT_HIGH:  cfg_next.right_high  = pwdata[SAMPLE_W-1:0];
                REG_CRUISE_DUTY: cfg_next.cruise_duty = pwdata[SPEED_W-1:0];
                REG_GAIN_P:      cfg_next.gain_p      = pwdata[GAIN_W-1:0];
                REG_GAIN_I:      cfg_next.gain_i      = pwdata[GAIN_W-1:0];
                REG_GAIN_D:      cfg_next.gain_d      = pwdata[GAIN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LEFT_LOW:    prdata = APB_DW'(cfg_reg.left_low);
            REG_LEFT_HIGH:   prdata = APB_DW'(cfg_reg.left_high);
            REG_RIGHT_LOW:   prdata = APB_DW'(cfg_reg.right_low);
            REG_RIGHT_HIGH:  prdata = APB_DW'(cfg_reg.right_high);
            REG_CRUISE_DUTY: prdata = APB_DW'(cfg_reg.cruise_duty);
            REG_GAIN_P:      prdata = cfg_reg.gain_p;
            REG_GAIN_I:      prdata = cfg_reg.gain_i;
            REG_GAIN_D:      prdata = cfg_reg.gain_d;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_low    <= LEFT_LOW_RST;
            cfg_reg.left_high   <= LEFT_HIGH_RST;
            cfg_reg.right_low   <= RIGHT_LOW_RST;
            cfg_reg.right_high  <= RIGHT_HIGH_RST;
            cfg_reg.cruise_duty <= CRUISE_DUTY_RST;
            cfg_reg.gain_p      <= GAIN_P_RST;
            cfg_reg.gain_i      <= GAIN_I_RST;
            cfg_reg.gain_d      <= GAIN_D_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/lfpd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_ctrl
// Sequencer: steps the datapath through both normalisations, the error
// update, the three gain products and the output load.
// ----------------------------------------------------------------------------
module lfpd_ctrl
    import lfpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_PREP_L = 11'b000_0000_0010,
        ST_DIV_L  = 11'b000_0000_0100,
        ST_PREP_R = 11'b000_0000_1000,
        ST_DIV_R  = 11'b000_0001_0000,
        ST_ERR    = 11'b000_0010_0000,
        ST_MUL_P  = 11'b000_0100_0000,
        ST_MUL_I  = 11'b000_1000_0000,
        ST_MUL_D  = 11'b001_0000_0000,
        ST_ACC_D  = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP_L;
                end
            end
            ST_PREP_L:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV_L;
            end
            ST_DIV_L:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_PREP_R;
                end
            end
            ST_PREP_R:
            begin
                cmd.prep       = 1'b1;
                cmd.prep_right = 1'b1;
                cmd.store_left = 1'b1;
                state_next     = ST_DIV_R;
            end
            ST_DIV_R:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = OP_P;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = OP_I;
                cmd.acc_en = 1'b1;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = OP_D;
                cmd.acc_en = 1'b1;
                state_next = ST_ACC_D;
            end
            ST_ACC_D:
            begin
                cmd.acc_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait for the output register to drain
                if (!m_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/lfpd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_datapath
// Clamp and scale, shared restoring divider, error and integral update,
// shared 32x32 gain multiplier with accumulator, speed and duty split.
// ----------------------------------------------------------------------------
module lfpd_datapath
    import lfpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [SAMPLE_W-1:0] left_sample,
    input  logic [SAMPLE_W-1:0] right_sample,
    output logic [DUTY_W-1:0]   left_fwd_duty,
    output logic [DUTY_W-1:0]   left_rev_duty,
    output logic [DUTY_W-1:0]   right_fwd_duty,
    output logic [DUTY_W-1:0]   right_rev_duty,
    output logic                line_lost
);

    // Saturate to +-255 and split into {reverse, forward}
    function automatic logic [2*DUTY_W-1:0] drive_split(
        input logic signed [DRIVE_W-1:0] v
    );
        logic signed [DRIVE_W-1:0] neg;
        logic [2*DUTY_W-1:0]       r;
        neg = -v;
        priority if (v > DRIVE_MAX)
            r = {{DUTY_W{1'b0}}, DUTY_FULL};
        else if (v < DRIVE_MIN)
            r = {DUTY_FULL, {DUTY_W{1'b0}}};
        else if (!v[DRIVE_W-1])
            r = {{DUTY_W{1'b0}}, v[DUTY_W-1:0]};
        else
            r = {neg[DUTY_W-1:0], {DUTY_W{1'b0}}};
        return r;
    endfunction

    // Item and intermediate registers
    logic [SAMPLE_W-1:0]       ls_reg;
    logic [SAMPLE_W-1:0]       rs_reg;
    logic [NUM_W-1:0]          div_rem_reg;
    logic [SAMPLE_W-1:0]       div_den_reg;
    logic [NORM_W-1:0]         div_quo_reg;
    logic [CNT_W-1:0]          div_cnt_reg;
    logic [NORM_W-1:0]         ln_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [NORM_W-1:0]         mag_reg;
    logic                      lost_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      prod_neg_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic [DUTY_W-1:0]         lf_reg;
    logic [DUTY_W-1:0]         lr_reg;
    logic [DUTY_W-1:0]         rf_reg;
    logic [DUTY_W-1:0]         rr_reg;
    logic                      line_lost_reg;
    // Controller state of the loop
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [ERR_W-1:0]   prev_reg;

    // Clamp and scale
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] clamped;
    logic [SAMPLE_W-1:0] offset;
    logic                below;
    logic [NUM_W-1:0]    num_scaled;
    logic [NUM_W-1:0]    num;
    logic [SAMPLE_W-1:0] den;

    always_comb
    begin
        if (cmd.prep_right)
        begin
            x  = rs_reg;
            lo = cfg.right_low;
            hi = cfg.right_high;
        end
        else
        begin
            x  = ls_reg;
            lo = cfg.left_low;
            hi = cfg.left_high;
        end
        below = (x < lo);
        priority if (below)
            clamped = lo;
        else if (x > hi)
            clamped = hi;
        else
            clamped = x;
        offset     = clamped - lo;
        num_scaled = NUM_W'(offset) * NUM_W'(SCALE_MAX);
        // zero range gives 0; inverted range gives 0 or full scale
        priority if (lo == hi)
        begin
            num = '0;
            den = SAMPLE_W'(1);
        end
        else if (lo > hi)
        begin
            num = below ? '0 : NUM_W'(SCALE_MAX);
            den = SAMPLE_W'(1);
        end
        else
        begin
            num = num_scaled;
            den = hi - lo;
        end
    end

    // Restoring divider, one quotient bit per cycle, MSB first
    logic [NUM_W-1:0] trial;
    logic             fits;

    assign trial           = NUM_W'(div_den_reg) << div_cnt_reg;
    assign fits            = (div_rem_reg >= trial);
    assign status.div_last = (div_cnt_reg == '0);

    // Error, integral and speed terms
    logic                      lost;
    logic signed [ERR_W-1:0]   err_new;
    logic signed [INTEG_W:0]   sum_wide;
    logic signed [DIFF_W-1:0]  diff_new;
    logic [ERR_W-1:0]          mag_full;

    always_comb
    begin
        lost     = (ln_reg < LOST_LEVEL) && (div_quo_reg < LOST_LEVEL);
        err_new  = lost ? prev_reg
                        : $signed({1'b0, ln_reg}) - $signed({1'b0, div_quo_reg});
        sum_wide = {integ_reg[INTEG_W-1], integ_reg}
                 + {{(INTEG_W-ERR_W+1){err_new[ERR_W-1]}}, err_new};
        priority if (sum_wide[INTEG_W] != sum_wide[INTEG_W-1])
            integ_next = sum_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        else
            integ_next = sum_wide[INTEG_W-1:0];
        diff_new = {err_new[ERR_W-1], err_new} - {prev_reg[ERR_W-1], prev_reg};
        mag_full = err_new[ERR_W-1] ? ERR_W'(-err_new) : ERR_W'(err_new);
    end

    logic [NORM_W-1:0]  mag_up;
    logic [SLOWP_W-1:0] slow_prod;
    logic [SLOW_W-1:0]  slow;
    logic [SPEED_W-1:0] speed_new;

    always_comb
    begin
        mag_up    = mag_reg + ROUND_UP;
        slow_prod = SLOWP_W'(mag_up) * SLOWP_W'(RECIP_20);
        slow      = slow_prod[RECIP_SH +: SLOW_W];
        if (cfg.cruise_duty < SPEED_W'(slow))
            speed_new = '0;
        else
            speed_new = cfg.cruise_duty - SPEED_W'(slow);
    end

    // Shared gain multiplier
    logic [GAIN_W-1:0] op_mag;
    logic [GAIN_W-1:0] op_gain;
    logic              op_neg;
    logic [DIFF_W-1:0] diff_mag;

    always_comb
    begin
        diff_mag = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
        unique case (cmd.mul_op)
            OP_P:
            begin
                op_mag  = GAIN_W'(mag_reg);
                op_neg  = err_reg[ERR_W-1];
                op_gain = cfg.gain_p;
            end
            OP_I:
            begin
                op_mag  = integ_reg[INTEG_W-1] ? GAIN_W'(-integ_reg)
                                               : GAIN_W'(integ_reg);
                op_neg  = integ_reg[INTEG_W-1];
                op_gain = cfg.gain_i;
            end
            OP_D:
            begin
                op_mag  = GAIN_W'(diff_mag);
                op_neg  = diff_reg[DIFF_W-1];
                op_gain = cfg.gain_d;
            end
            default:
            begin
                op_mag  = '0;
                op_neg  = 1'b0;
                op_gain = '0;
            end
        endcase
    end

    logic [TERM_W-1:0]        term;
    logic signed [ACC_W-1:0]  term_s;

    assign term   = prod_reg[PROD_W-1:FRAC_BITS];
    assign term_s = prod_neg_reg ? -$signed({2'b00, term}) : $signed({2'b00, term});

    // Wheel drive
    logic signed [DRIVE_W-1:0] speed_ext;
    logic signed [DRIVE_W-1:0] acc_ext;
    logic [2*DUTY_W-1:0]       left_split;
    logic [2*DUTY_W-1:0]       right_split;

    assign speed_ext   = $signed({{(DRIVE_W-SPEED_W){1'b0}}, speed_reg});
    assign acc_ext     = {acc_reg[ACC_W-1], acc_reg};
    assign left_split  = drive_split(speed_ext + acc_ext);
    assign right_split = drive_split(speed_ext - acc_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else if (cmd.calc_err)
        begin
            integ_reg <= integ_next;
            prev_reg  <= err_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ls_reg <= left_sample;
            rs_reg <= right_sample;
        end
        if (cmd.prep)
        begin
            div_rem_reg <= num;
            div_den_reg <= den;
            div_quo_reg <= '0;
            div_cnt_reg <= DIV_LAST_BIT;
        end
        else if (cmd.div_step)
        begin
            if (fits)
            begin
                div_rem_reg <= div_rem_reg - trial;
            end
            div_quo_reg <= {div_quo_reg[NORM_W-2:0], fits};
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
        if (cmd.store_left)
        begin
            ln_reg <= div_quo_reg;
        end
        if (cmd.calc_err)
        begin
            err_reg  <= err_new;
            diff_reg <= diff_new;
            mag_reg  <= mag_full[NORM_W-1:0];
            lost_reg <= lost;
            acc_reg  <= '0;
        end
        if (cmd.mul_en)
        begin
            prod_reg     <= PROD_W'(op_mag) * PROD_W'(op_gain);
            prod_neg_reg <= op_neg;
            speed_reg    <= speed_new;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + term_s;
        end
        if (cmd.out_load)
        begin
            lf_reg        <= left_split[DUTY_W-1:0];
            lr_reg        <= left_split[2*DUTY_W-1:DUTY_W];
            rf_reg        <= right_split[DUTY_W-1:0];
            rr_reg        <= right_split[2*DUTY_W-1:DUTY_W];
            line_lost_reg <= lost_reg;
        end
    end

    assign left_fwd_duty  = lf_reg;
    assign left_rev_duty  = lr_reg;
    assign right_fwd_duty = rf_reg;
    assign right_rev_duty = rr_reg;
    assign line_lost      = line_lost_reg;

endmodule
`default_nettype wire

FILE: rtl/core/line_follow_pid_drive_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_follow_pid_drive_unit
// PID line follower for a two-wheel differential drive.
// ----------------------------------------------------------------------------
// Each input transaction carries one left/right pair of 12-bit reflectance
// samples (one control tick) and yields exactly one output transaction with
// forward and reverse duties for both wheels plus a line-lost flag. Samples
// are clamped to their calibrated bounds and scaled to 0..1000, the error is
// left minus right (the last error is held when both readings sit below 100),
// and P, I and D terms are formed with Q8.24 gains from the saturating 32-bit
// integral and the previous error. An item occupies the block from its
// acceptance until its result is loaded into the output register, taking two
// passes through the shared restoring divider; the three gain products share
// one 32x32 multiplier. A new sample pair is taken while a finished result
// still sits unclaimed in the output register; the block only holds in its
// output step if that register is still full. Configuration is to be written
// over APB only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module line_follow_pid_drive_unit
    import lfpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // sample stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // [11:0] left_sample, [23:12] right_sample
    // drive stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [7:0] left_fwd_duty, [15:8] left_rev_duty,
                                         // [23:16] right_fwd_duty, [31:24] right_rev_duty
    output logic [0:0]        m_tuser,   // [0] line_lost
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    logic [DUTY_W-1:0] left_fwd_duty;
    logic [DUTY_W-1:0] left_rev_duty;
    logic [DUTY_W-1:0] right_fwd_duty;
    logic [DUTY_W-1:0] right_rev_duty;
    logic              line_lost;

    // Register file
    lfpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: owns both handshakes, drives the datapath by command
    lfpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and loop state; output register lives here too
    lfpd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .left_sample    (s_tdata[SAMPLE_W-1:0]),
        .right_sample   (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .left_fwd_duty  (left_fwd_duty),
        .left_rev_duty  (left_rev_duty),
        .right_fwd_duty (right_fwd_duty),
        .right_rev_duty (right_rev_duty),
        .line_lost      (line_lost)
    );

    // Pack the result, first field in the lowest bits
    assign m_tdata = {right_rev_duty, right_fwd_duty, left_rev_duty, left_fwd_duty};
    assign m_tuser = line_lost;

    // A taken sample pair keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sample taken while previous item still in progress");

    // A wheel never drives forward and reverse at once
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[15:8] == 8'd0))
        else $error("left wheel has both forward and reverse duty");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:16] == 8'd0 || m_tdata[31:24] == 8'd0))
        else $error("right wheel has both forward and reverse duty");

endmodule
`default_nettype wire
